// ===== design/sra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_pkg
// Types and constants shared by the stable rank assignment block.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;
  localparam int BITS_W  = 3;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [BITS_W-1:0] rank_bits;
    logic              overflow;
    logic              last_result;
  } result_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_FETCH,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Position of the highest set bit plus one; zero for zero.
  function automatic logic [BITS_W-1:0] bit_length(input logic [COUNT_W-1:0] m);
    logic [BITS_W-1:0] b;
    b = '0;
    for (int k = 0; k < COUNT_W; k++) begin
      if (m[k]) begin
        b = BITS_W'(k + 1);
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== design/stable_rank_assignment.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_rank_assignment
// Collects a set of signed values and returns each one's stable ascending rank.
// ----------------------------------------------------------------------------
// Values arrive one beat per cycle and are written to a value memory; the beat
// marked last closes the set (beats beyond MAX_ITEMS are dropped and flagged).
// The block then produces one result beat per stored value in arrival order.
// Each rank is found by sweeping the value memory through its single read
// port: a fetch of the value being ranked, a capture of that value, a compare
// of each stored value in turn, and an output beat, which may stall on the
// result side. No new value is taken while a set is being ranked.
module stable_rank_assignment #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire sra_pkg::item_t  item,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output sra_pkg::result_t     result
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int RW = sra_pkg::RANK_W;
  localparam int KW = sra_pkg::COUNT_W;
  localparam int VW = sra_pkg::VALUE_W;
  localparam int BW = sra_pkg::BITS_W;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ITEMS);

  sra_pkg::state_t state, state_next;

  logic [CW-1:0] count;
  logic          ovf;
  logic [BW-1:0] bits;
  logic [AW-1:0] idx_i;
  logic [AW-1:0] idx_j;
  logic [AW-1:0] idx_jd;
  logic          capture;
  logic [VW-1:0] vi;
  logic [AW-1:0] rank_acc;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  logic          item_beat;
  logic          result_beat;
  logic          has_room;
  logic [CW-1:0] count_close;
  logic [CW-1:0] n_minus_one;
  logic          hit;
  logic          scan_done;
  logic          is_last;

  sra_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_ITEMS)
  ) u_value_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(item.value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign item_beat   = item_valid && item_ready;
  assign result_beat = result_valid && result_ready;
  assign has_room    = count < MAX_COUNT;
  assign count_close = has_room ? count + CW'(1) : count;
  assign n_minus_one = count - CW'(1);
  assign scan_done   = CW'(idx_jd) == n_minus_one;
  assign is_last     = CW'(idx_i) == n_minus_one;

  // Earlier arrivals win ties, which keeps the ranking stable.
  assign hit = ($signed(ram_rdata) < $signed(vi)) ||
               ((ram_rdata == vi) && (idx_jd < idx_i));

  always_comb begin
    state_next = state;
    case (state)
      sra_pkg::ST_COLLECT: begin
        if (item_beat && item.last_item) begin
          state_next = sra_pkg::ST_FETCH;
        end
      end
      sra_pkg::ST_FETCH: state_next = sra_pkg::ST_SCAN;
      sra_pkg::ST_SCAN: begin
        if (!capture && scan_done) begin
          state_next = sra_pkg::ST_EMIT;
        end
      end
      sra_pkg::ST_EMIT: begin
        if (result_beat) begin
          state_next = is_last ? sra_pkg::ST_COLLECT : sra_pkg::ST_FETCH;
        end
      end
      default: state_next = sra_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    result_valid = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = idx_j;
    case (state)
      sra_pkg::ST_COLLECT: begin
        item_ready = 1'b1;
        ram_we     = item_valid && has_room;
      end
      sra_pkg::ST_FETCH: ram_raddr = idx_i;
      sra_pkg::ST_SCAN: begin
        if (capture) begin
          ram_raddr = '0;
        end
      end
      sra_pkg::ST_EMIT: result_valid = 1'b1;
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.rank        = RW'(rank_acc);
    result.rank_bits   = bits;
    result.overflow    = ovf;
    result.last_result = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sra_pkg::ST_COLLECT;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        sra_pkg::ST_COLLECT: begin
          if (item_beat) begin
            count <= count_close;
            if (!has_room) begin
              ovf <= 1'b1;
            end
          end
        end
        sra_pkg::ST_EMIT: begin
          if (result_beat && is_last) begin
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Sweep bookkeeping; these need no reset as the control state steers them.
  always_ff @(posedge clk) begin
    case (state)
      sra_pkg::ST_COLLECT: begin
        idx_i <= '0;
        bits  <= sra_pkg::bit_length(KW'(count_close - CW'(1)));
      end
      sra_pkg::ST_FETCH: begin
        capture <= 1'b1;
      end
      sra_pkg::ST_SCAN: begin
        if (capture) begin
          // The fetched value being ranked lands in this cycle.
          capture  <= 1'b0;
          vi       <= ram_rdata;
          rank_acc <= '0;
          idx_j    <= AW'(1);
          idx_jd   <= '0;
        end else begin
          rank_acc <= rank_acc + AW'(hit);
          idx_j    <= idx_j + AW'(1);
          idx_jd   <= idx_jd + AW'(1);
        end
      end
      sra_pkg::ST_EMIT: begin
        if (result_beat && !is_last) begin
          idx_i <= idx_i + AW'(1);
        end
      end
      default: begin
        capture <= 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/sra_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sim/rank_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_checker
// Watches both channels of stable_rank_assignment and checks every rank beat.
// ----------------------------------------------------------------------------
// Each accepted input beat, up to MAX_ITEMS per set, goes into a copy of the
// value set. When the closing beat arrives, the stable ascending rank of every
// stored value is worked out and queued in arrival order. Each accepted result
// beat is then compared field by field with the oldest queued rank.
// ----------------------------------------------------------------------------
module rank_checker #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic             item_ready,
  input  wire sra_pkg::item_t   item,
  input  wire logic             result_valid,
  input  wire logic             result_ready,
  input  wire sra_pkg::result_t result,
  output int                    failures,
  output int                    outstanding,
  output int                    ranks_checked,
  output int                    sets_closed,
  output int                    sets_overflowed
);

  logic signed [sra_pkg::VALUE_W-1:0] held_values [MAX_ITEMS];
  int               held_count;
  bit               dropped_any;
  sra_pkg::result_t expected_ranks [$];
  int               fail_tally;
  int               checked_tally;
  int               closed_tally;
  int               overflow_tally;

  // Ranks every held value: smaller values first, and on a tie the earlier
  // arrival first. The width is that of the largest rank, count minus one.
  function automatic void rank_held_set();
    int                         unsigned span;
    int                         r;
    logic [sra_pkg::BITS_W-1:0] max_rank_width;
    sra_pkg::result_t           beat;
    span = held_count - 1;
    max_rank_width = '0;
    while (span != 0) begin
      max_rank_width++;
      span = span >> 1;
    end
    for (int i = 0; i < held_count; i++) begin
      r = 0;
      for (int j = 0; j < held_count; j++) begin
        if (held_values[j] < held_values[i] ||
            (held_values[j] == held_values[i] && j < i)) begin
          r++;
        end
      end
      beat.rank        = r[sra_pkg::RANK_W-1:0];
      beat.rank_bits   = max_rank_width;
      beat.overflow    = dropped_any;
      beat.last_result = (i == held_count - 1);
      expected_ranks.push_back(beat);
    end
    closed_tally++;
    if (dropped_any) begin
      overflow_tally++;
    end
    held_count  = 0;
    dropped_any = 1'b0;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin : watch
    sra_pkg::result_t want;
    if (rst) begin
      expected_ranks.delete();
      held_count     = 0;
      dropped_any    = 1'b0;
      fail_tally     = 0;
      checked_tally  = 0;
      closed_tally   = 0;
      overflow_tally = 0;
    end else begin
      if (item_valid && item_ready) begin
        if (held_count < MAX_ITEMS) begin
          held_values[held_count] = item.value;
          held_count++;
        end else begin
          dropped_any = 1'b1;
        end
        if (item.last_item) begin
          rank_held_set();
        end
      end
      if (result_valid && result_ready) begin
        if (expected_ranks.size() == 0) begin
          $display("%0t: rank beat with nothing expected, rank %0d", $time, result.rank);
          fail_tally++;
        end else begin
          want = expected_ranks.pop_front();
          compare_field("rank", 8'(want.rank), 8'(result.rank));
          compare_field("rank_bits", 8'(want.rank_bits), 8'(result.rank_bits));
          compare_field("overflow", 8'(want.overflow), 8'(result.overflow));
          compare_field("last_result", 8'(want.last_result), 8'(result.last_result));
          checked_tally++;
        end
      end
    end
    failures        <= fail_tally;
    outstanding     <= expected_ranks.size();
    ranks_checked   <= checked_tally;
    sets_closed     <= closed_tally;
    sets_overflowed <= overflow_tally;
  end

endmodule

// ===== sim/tb_stable_rank_assignment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_rank_assignment
// Drives value sets into stable_rank_assignment and checks the returned ranks.
// ----------------------------------------------------------------------------
// A short directed part covers the value extremes, ties, single-element sets
// and sorted inputs. Random sets follow, most of them small, with one full set
// and one that runs past capacity, including a dropped closing beat. Both
// sides idle at random, and the result side holds off once for a long stretch.
// The checker beside the block predicts and compares every rank beat.
// ----------------------------------------------------------------------------
module tb_stable_rank_assignment;

  localparam int SET_CAP        = 64;
  localparam int ITEM_TARGET    = 270;
  localparam int HOLD_AFTER     = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;
  localparam logic signed [sra_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [sra_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  sra_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  sra_pkg::result_t result;

  int failures;
  int outstanding;
  int ranks_checked;
  int sets_closed;
  int sets_overflowed;
  int items_sent;
  int largest_set;
  int quiet_cycles;
  bit idling;

  always #5 clk = ~clk;

  stable_rank_assignment #(
    .MAX_ITEMS(SET_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  rank_checker #(
    .MAX_ITEMS(SET_CAP)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .failures(failures),
    .outstanding(outstanding),
    .ranks_checked(ranks_checked),
    .sets_closed(sets_closed),
    .sets_overflowed(sets_overflowed)
  );

  // Mostly no gap or a short one, now and then a long one.
  function automatic int idle_len();
    int p;
    if (!idling) begin
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 60) begin
      return 0;
    end
    if (p < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // A mix of full-range values, a narrow band that gives many ties, the extremes
  // of the signed range, and small values shifted left by a random amount.
  function automatic logic signed [sra_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(0, 2)) << $urandom_range(0, 31);
    endcase
  endfunction

  // Entered and left at a falling edge; returns once the beat is accepted.
  task automatic offer_item(input logic signed [sra_pkg::VALUE_W-1:0] v,
                            input logic last);
    int             gap;
    sra_pkg::item_t beat;
    beat.value     = v;
    beat.last_item = last;
    gap = idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_set(input int n);
    for (int k = 0; k < n; k++) begin
      offer_item(pick_value(), k == n - 1);
    end
    if (n > largest_set) begin
      largest_set = n;
    end
  endtask

  initial begin : stimulus
    int set_no;
    int size;
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    items_sent  = 0;
    largest_set = 0;
    idling      = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single-element sets at both ends of the range.
    offer_item(VAL_MIN, 1'b1);
    offer_item(VAL_MAX, 1'b1);
    // Extremes and alternating bit patterns.
    offer_item(VAL_MAX, 1'b0);
    offer_item(VAL_MIN, 1'b0);
    offer_item(0, 1'b0);
    offer_item(-1, 1'b0);
    offer_item(32'sh5555_5555, 1'b0);
    offer_item(32'shaaaa_aaaa, 1'b1);
    // Ties must keep their arrival order.
    offer_item(5, 1'b0);
    offer_item(5, 1'b0);
    offer_item(5, 1'b0);
    offer_item(-3, 1'b0);
    offer_item(5, 1'b0);
    offer_item(-3, 1'b1);
    offer_item(0, 1'b0);
    offer_item(0, 1'b1);
    // Already sorted, both ways round.
    offer_item(3, 1'b0);
    offer_item(2, 1'b0);
    offer_item(1, 1'b0);
    offer_item(0, 1'b1);
    offer_item(-2, 1'b0);
    offer_item(-1, 1'b0);
    offer_item(0, 1'b0);
    offer_item(1, 1'b1);
    largest_set = 6;

    // One set fills the store exactly; another runs two beats past it, so
    // the closing beat itself is dropped.
    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      idling = ($urandom_range(0, 3) != 0);
      if (set_no == 2) begin
        size = SET_CAP;
      end else if (set_no == 6) begin
        size = SET_CAP + 2;
      end else begin
        size = $urandom_range(1, 10);
      end
      send_set(size);
      set_no++;
    end
    item_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats in %0d sets, largest %0d; %0d sets overflowed.",
             items_sent, sets_closed, largest_set, sets_overflowed);
    $display("Checked %0d rank beats with %0d field errors.", ranks_checked, failures);
    if (failures == 0 && outstanding == 0) begin
      $display("stable_rank_assignment: match");
    end else begin
      $display("stable_rank_assignment: mismatch");
    end
    $finish;
  end

  // Result side: random stalls, and once a long hold-off so that the block
  // backs up and stops taking input beats.
  initial begin : result_side
    int gap;
    bit held_off;
    result_ready = 1'b0;
    held_off     = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!held_off && ranks_checked >= HOLD_AFTER) begin
        held_off = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_ready <= 1'b1;
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          result_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
        $display("stable_rank_assignment: mismatch");
        $finish;
      end
    end
  end

endmodule
